// File: hdl/bal_pkg.sv
package bal_pkg;

   // Default geometry
   localparam int LIST_DEPTH = 16;
   localparam int DATA_WIDTH = 32;

   // Field widths of the request and response words
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND       = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_AT    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DELETE_FRONT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DELETE_LAST  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_DELETE_AT    = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH       = 3'd6;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   // Command broadcast along the cell row
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SEARCH
   } cell_mode_type;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  found_index;
      logic [COUNT_W-1:0]  entry_count;
      logic                is_empty;
      logic                is_full;
   } rsp_type;

endpackage

// File: hdl/bal_cell.sv
module bal_cell #(
   parameter int DATA_WIDTH = bal_pkg::DATA_WIDTH,
   parameter int IW         = 4,
   parameter int CW         = 5,
   parameter int INDEX      = 0
) (
   input  logic                   clock,
   input  bal_pkg::cell_mode_type mode,
   input  logic [IW-1:0]          pos,
   input  logic [CW-1:0]          limit,
   input  logic [DATA_WIDTH-1:0]  word,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [DATA_WIDTH-1:0]  data,
   output logic                   match
);

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
   localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      unique case (mode)
         bal_pkg::CELL_INSERT: begin
            // entries above the gap move up, the gap takes the new word
            if (MY_IDX > pos) begin
               data_in = left_data;
            end else if (MY_IDX == pos) begin
               data_in = word;
            end
         end
         bal_pkg::CELL_DELETE: begin
            if (MY_IDX >= pos) begin
               data_in = right_data;
            end
         end
         bal_pkg::CELL_SEARCH: begin
            match_in = (data_ff == word) && (MY_CNT < limit);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

// File: hdl/bounded_array_list_engine_unit.sv
// The response strobe comes in the cycle after the request is taken.
// Busy is high in the cycle the response shows, while the match row from
// the cells is priority encoded; no request is taken while busy is high.
// Reset (synchronous, active high) empties the list and clears busy and the
// response strobe; entry storage is not cleared. The receiver cannot stall.
module bounded_array_list_engine_unit #(
   parameter int LIST_DEPTH = bal_pkg::LIST_DEPTH,
   parameter int DATA_WIDTH = bal_pkg::DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  bal_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output bal_pkg::rsp_type rsp_data
);

   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int PW = bal_pkg::POS_W;

   // ---------------- control registers ----------------
   logic                          pending_ff, pending_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [bal_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                          search_ff, search_in;

   // ---------------- command decode ----------------
   logic                  accept;
   logic                  full, empty, pos_ok;
   bal_pkg::cell_mode_type mode;
   logic [IW-1:0]         cell_pos;
   logic [DATA_WIDTH-1:0] word;

   assign accept = start && !busy;
   assign full   = (count_ff == CW'(LIST_DEPTH));
   assign empty  = (count_ff == '0);
   // position must name an existing entry
   assign pos_ok = ({{CW{1'b0}}, req_data.position} < {{PW{1'b0}}, count_ff});
   // value is kept in its low DATA_WIDTH bits (sign-extended when wider)
   assign word   = DATA_WIDTH'(req_data.value);

   always_comb begin
      mode      = bal_pkg::CELL_HOLD;
      cell_pos  = '0;
      count_in  = count_ff;
      status_in = status_ff;
      search_in = search_ff;
      if (accept) begin
         status_in = bal_pkg::STATUS_OK;
         search_in = 1'b0;
         unique case (req_data.func)
            bal_pkg::FUNC_INSERT_FRONT: begin
               if (full) begin
                  status_in = bal_pkg::STATUS_FULL;
               end else begin
                  mode     = bal_pkg::CELL_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            bal_pkg::FUNC_APPEND: begin
               if (full) begin
                  status_in = bal_pkg::STATUS_FULL;
               end else begin
                  // not full, so the count fits the index width
                  mode     = bal_pkg::CELL_INSERT;
                  cell_pos = IW'(count_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            bal_pkg::FUNC_INSERT_AT: begin
               if (full) begin
                  status_in = bal_pkg::STATUS_FULL;
               end else if (!pos_ok) begin
                  status_in = bal_pkg::STATUS_BAD_POS;
               end else begin
                  mode     = bal_pkg::CELL_INSERT;
                  cell_pos = IW'(req_data.position);
                  count_in = count_ff + 1'b1;
               end
            end
            bal_pkg::FUNC_DELETE_FRONT: begin
               if (empty) begin
                  status_in = bal_pkg::STATUS_EMPTY;
               end else begin
                  mode     = bal_pkg::CELL_DELETE;
                  count_in = count_ff - 1'b1;
               end
            end
            bal_pkg::FUNC_DELETE_LAST: begin
               // dropping the top entry needs only the count
               if (empty) begin
                  status_in = bal_pkg::STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            bal_pkg::FUNC_DELETE_AT: begin
               if (empty) begin
                  status_in = bal_pkg::STATUS_EMPTY;
               end else if (!pos_ok) begin
                  status_in = bal_pkg::STATUS_BAD_POS;
               end else begin
                  mode     = bal_pkg::CELL_DELETE;
                  cell_pos = IW'(req_data.position);
                  count_in = count_ff - 1'b1;
               end
            end
            bal_pkg::FUNC_SEARCH: begin
               // every cell compares at once; result resolved next cycle
               mode      = bal_pkg::CELL_SEARCH;
               search_in = 1'b1;
            end
            default: begin
               // unused function code
               status_in = bal_pkg::STATUS_BAD_POS;
            end
         endcase
      end
   end

   assign pending_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
      status_ff <= status_in;
      search_ff <= search_in;
   end

   // ---------------- cell row ----------------
   logic [DATA_WIDTH-1:0] cell_data [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] cell_match;

   for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_word, right_word;
      if (k == 0) begin : g_first
         assign left_word = word;
      end else begin : g_mid
         assign left_word = cell_data[k-1];
      end
      if (k == LIST_DEPTH - 1) begin : g_last
         assign right_word = cell_data[k];
      end else begin : g_inner
         assign right_word = cell_data[k+1];
      end
      bal_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IW         (IW),
         .CW         (CW),
         .INDEX      (k)
      ) u_cell (
         .clock      (clock),
         .mode       (mode),
         .pos        (cell_pos),
         .limit      (count_ff),
         .word       (word),
         .left_data  (left_word),
         .right_data (right_word),
         .data       (cell_data[k]),
         .match      (cell_match[k])
      );
   end

   // ---------------- response ----------------
   // lowest matching cell wins
   logic [IW-1:0] hit_index;
   logic          hit;

   always_comb begin
      hit_index = '0;
      for (int k = LIST_DEPTH - 1; k >= 0; k--) begin
         if (cell_match[k]) begin
            hit_index = IW'(k);
         end
      end
   end

   assign hit = |cell_match;

   always_comb begin
      rsp_data             = '0;
      rsp_data.entry_count = bal_pkg::COUNT_W'(count_ff);
      rsp_data.is_empty    = (count_ff == '0);
      rsp_data.is_full     = (count_ff == CW'(LIST_DEPTH));
      if (search_ff) begin
         if (hit) begin
            rsp_data.status      = bal_pkg::STATUS_OK;
            rsp_data.found_index = bal_pkg::INDEX_W'(hit_index);
         end else begin
            rsp_data.status = bal_pkg::STATUS_NOT_FOUND;
         end
      end else begin
         rsp_data.status = status_ff;
      end
   end

   assign rsp_valid = pending_ff;
   assign busy      = pending_ff;

endmodule

// File: hdl/bal_checker.sv
module bal_checker #(
   parameter int LIST_DEPTH = bal_pkg::LIST_DEPTH
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input bal_pkg::rsp_type rsp_data
);

   // every accepted word answers in the next cycle
   a_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("accepted word got no response");

   // no response without a request the cycle before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("response without request");

   // flags agree with the count
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == '0)) &&
                    (rsp_data.is_full ==
                     (rsp_data.entry_count == bal_pkg::COUNT_W'(LIST_DEPTH))))
      else $error("empty or full flag disagrees with count");

   // any response other than OK, a search miss among them, reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != bal_pkg::STATUS_OK) |->
         rsp_data.found_index == '0)
      else $error("found index set on failed request");

endmodule

bind bounded_array_list_engine_unit bal_checker #(
   .LIST_DEPTH (LIST_DEPTH)
) u_bal_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// File: tb/bounded_array_list_engine_unit_tb.sv
`timescale 1ns / 100ps

module bounded_array_list_engine_unit_tb;
   import bal_pkg::*;

   // Code 7 is not an operation; the block must reject it as a bad position.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

   localparam int RANDOM_WORDS   = 1280;
   localparam int QUIET_TAIL     = 150;   // final stretch runs with no gaps
   localparam int WATCHDOG_LIMIT = 200;   // cycles with no word moving
   localparam int DRAIN_CYCLES   = 4;     // settle time after the last response
   localparam int REQ_W          = $bits(req_type);

   // Shadow of the list plus the queue of responses still owed by the block.
   class array_list_mirror;
      logic [DATA_WIDTH-1:0] slots [LIST_DEPTH];
      int unsigned           fill;
      rsp_type               owed_rsp[$];
      int unsigned           errors;
      int unsigned           checked;
      int unsigned           status_seen [8];
      int unsigned           search_hits;
      int unsigned           times_full;
      int unsigned           times_emptied;

      function new();
         fill = 0;
         errors = 0;
         checked = 0;
         search_hits = 0;
         times_full = 0;
         times_emptied = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function int unsigned pending();
         return owed_rsp.size();
      endfunction

      function void open_slot(int unsigned at, logic [DATA_WIDTH-1:0] w);
         int unsigned k;
         for (k = fill; k > at; k--) slots[k] = slots[k-1];
         slots[at] = w;
         fill++;
      endfunction

      function void close_slot(int unsigned at);
         int unsigned k;
         for (k = at; k + 1 < fill; k++) slots[k] = slots[k+1];
         fill--;
      endfunction

      // Accepted request: update the shadow list and queue what must come back.
      function void note_request(req_type r);
         rsp_type               e;
         logic [DATA_WIDTH-1:0] w;
         int unsigned           p;
         int unsigned           k;
         bit                    was_full;
         bit                    was_empty;
         w         = r.value[DATA_WIDTH-1:0];
         p         = 32'(r.position);
         was_full  = (fill >= LIST_DEPTH);
         was_empty = (fill == 0);
         e         = '0;
         e.status  = STATUS_OK;
         case (r.func)
            FUNC_INSERT_FRONT: begin
               if (was_full) e.status = STATUS_FULL;
               else open_slot(0, w);
            end
            FUNC_APPEND: begin
               if (was_full) e.status = STATUS_FULL;
               else open_slot(fill, w);
            end
            FUNC_INSERT_AT: begin
               if (was_full) e.status = STATUS_FULL;
               else if (p >= fill) e.status = STATUS_BAD_POS;
               else open_slot(p, w);
            end
            FUNC_DELETE_FRONT: begin
               if (was_empty) e.status = STATUS_EMPTY;
               else close_slot(0);
            end
            FUNC_DELETE_LAST: begin
               if (was_empty) e.status = STATUS_EMPTY;
               else fill--;
            end
            FUNC_DELETE_AT: begin
               if (was_empty) e.status = STATUS_EMPTY;
               else if (p >= fill) e.status = STATUS_BAD_POS;
               else close_slot(p);
            end
            FUNC_SEARCH: begin
               // lowest matching index wins
               e.status = STATUS_NOT_FOUND;
               for (k = 0; k < fill && e.status != STATUS_OK; k++) begin
                  if (slots[k] == w) begin
                     e.status      = STATUS_OK;
                     e.found_index = INDEX_W'(k);
                  end
               end
               if (e.status == STATUS_OK) search_hits++;
            end
            default: e.status = STATUS_BAD_POS;
         endcase
         e.entry_count = COUNT_W'(fill);
         e.is_empty    = (fill == 0);
         e.is_full     = (fill >= LIST_DEPTH);
         if (e.is_full && !was_full) times_full++;
         if (e.is_empty && !was_empty) times_emptied++;
         status_seen[e.status]++;
         owed_rsp.push_back(e);
      endfunction

      // four-state compare so unknown bits from the block count as mismatches
      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
         if (exp_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (owed_rsp.size() == 0) begin
            $display("%0t: response with none outstanding: expected nothing, actual %p",
                     $time, got);
            errors++;
            return;
         end
         e = owed_rsp.pop_front();
         checked++;
         compare_field("status", 32'(e.status), 32'(got.status));
         compare_field("found_index", 32'(e.found_index), 32'(got.found_index));
         compare_field("entry_count", 32'(e.entry_count), 32'(got.entry_count));
         compare_field("is_empty", 32'(e.is_empty), 32'(got.is_empty));
         compare_field("is_full", 32'(e.is_full), 32'(got.is_full));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   array_list_mirror sb;
   int unsigned      words_sent;
   int               quiet_cycles;

   bounded_array_list_engine_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Response checker and watchdog. Samples pre-edge values, so it sees the
   // same start/busy the block saw at this edge.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid) sb.check_response(rsp_data);
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d responses outstanding", $time, sb.pending());
            $display("bounded_array_list_engine_unit test failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Present one word and hold it until the block takes it (start high,
   // busy low at the edge). Returns on the accepting edge.
   task automatic issue_word(req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      words_sent++;
   endtask

   // Sender gap; junk on the data lines must be ignored.
   task automatic idle_cycles(int n);
      start    <= 1'b0;
      req_data <= REQ_W'({$urandom, $urandom});
      repeat (n) @(posedge clock);
   endtask

   // Hold off until every outstanding response is back.
   task automatic drain_responses();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [FUNC_W-1:0] f, logic [31:0] v,
                                        logic [POS_W-1:0] p);
      req_type r;
      r.func     = f;
      r.value    = v;
      r.position = p;
      return r;
   endfunction

   // Small pool of values so duplicates and search hits are common.
   function automatic logic [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h5555_5555;
            5: return 32'hAAAA_AAAA;
            6: return 32'd10;
            default: return 32'd1;
         endcase
      end
      return $urandom;
   endfunction

   // mode 0 grows the list, 1 shrinks it, 2 mixes growing and shrinking
   function automatic req_type make_random_req(int mode);
      req_type     r;
      int          roll;
      int          grow_pct;
      int unsigned n;
      n          = sb.fill;
      r.value    = pick_value();
      r.position = POS_W'($urandom_range(0, 15));
      // mostly valid positions, else anything in the field
      if (n > 0 && $urandom_range(0, 3) != 0) r.position = POS_W'($urandom_range(0, n - 1));
      grow_pct = (mode == 0) ? 70 : (mode == 1) ? 22 : 46;
      roll     = $urandom_range(0, 99);
      if (roll < 2) begin
         r.func = FUNC_UNUSED;
      end else if (roll < 16) begin
         r.func = FUNC_SEARCH;
         if (n > 0 && $urandom_range(0, 2) != 0) r.value = sb.slots[$urandom_range(0, n - 1)];
      end else if ($urandom_range(0, 99) < grow_pct) begin
         case ($urandom_range(0, 2))
            0: r.func = FUNC_INSERT_FRONT;
            1: r.func = FUNC_APPEND;
            default: r.func = FUNC_INSERT_AT;
         endcase
      end else begin
         case ($urandom_range(0, 2))
            0: r.func = FUNC_DELETE_FRONT;
            1: r.func = FUNC_DELETE_LAST;
            default: r.func = FUNC_DELETE_AT;
         endcase
      end
      return r;
   endfunction

   initial begin
      int unsigned rnd_done;
      int          mode;
      int          seg_len;
      int          gap_pct;
      int          i;

      sb         = new();
      words_sent = 0;
      clock      = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed words ----
      // empty list: search, all three deletes, insert-at with no valid slot, unused code
      issue_word(make_req(FUNC_SEARCH,       32'h0,         4'd0));
      issue_word(make_req(FUNC_DELETE_FRONT, 32'h0,         4'd0));
      issue_word(make_req(FUNC_DELETE_LAST,  32'h0,         4'd0));
      issue_word(make_req(FUNC_DELETE_AT,    32'h0,         4'd15));
      issue_word(make_req(FUNC_INSERT_AT,    32'h1234_5678, 4'd0));
      issue_word(make_req(FUNC_UNUSED,       32'hFFFF_FFFF, 4'd15));
      // value extremes, insert in the middle
      issue_word(make_req(FUNC_APPEND,       32'h7FFF_FFFF, 4'd0));
      issue_word(make_req(FUNC_INSERT_FRONT, 32'h8000_0000, 4'd0));
      issue_word(make_req(FUNC_INSERT_AT,    32'hFFFF_FFFF, 4'd1));
      issue_word(make_req(FUNC_APPEND,       32'h0000_0000, 4'd0));
      // search hits at index 1 and at index 2, then a miss
      issue_word(make_req(FUNC_SEARCH,       32'hFFFF_FFFF, 4'd0));
      issue_word(make_req(FUNC_SEARCH,       32'h7FFF_FFFF, 4'd0));
      issue_word(make_req(FUNC_SEARCH,       32'd12345,     4'd0));
      // position equal to count and far past it
      issue_word(make_req(FUNC_INSERT_AT,    32'd7,         4'd4));
      issue_word(make_req(FUNC_DELETE_AT,    32'd0,         4'd15));
      // duplicate value: search must return the lowest index
      issue_word(make_req(FUNC_APPEND,       32'hFFFF_FFFF, 4'd0));
      issue_word(make_req(FUNC_SEARCH,       32'hFFFF_FFFF, 4'd0));
      issue_word(make_req(FUNC_DELETE_AT,    32'd0,         4'd1));
      issue_word(make_req(FUNC_DELETE_FRONT, 32'd0,         4'd0));
      issue_word(make_req(FUNC_DELETE_LAST,  32'd0,         4'd0));
      issue_word(make_req(FUNC_INSERT_FRONT, 32'h5555_5555, 4'd0));
      issue_word(make_req(FUNC_INSERT_AT,    32'hAAAA_AAAA, 4'd0));
      issue_word(make_req(FUNC_UNUSED,       32'h0,         4'd0));

      // ---- random words in segments ----
      // Each segment pushes the list toward full, toward empty, or holds it
      // mid-range. Segment boundaries wait for all responses (back-pressure
      // on the sender side); some segments run with no gaps at all.
      rnd_done = 0;
      while (rnd_done < RANDOM_WORDS) begin
         drain_responses();
         mode    = $urandom_range(0, 2);
         seg_len = $urandom_range(30, 90);
         gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
         for (i = 0; i < seg_len && rnd_done < RANDOM_WORDS; i++) begin
            if (rnd_done < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 99) < gap_pct)
               idle_cycles($urandom_range(1, 19));
            issue_word(make_random_req(mode));
            rnd_done++;
         end
      end

      // ---- wind down ----
      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words, %0d checked: ok %0d, full %0d, empty %0d, bad position %0d",
               words_sent, sb.checked, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_FULL],
               sb.status_seen[STATUS_EMPTY], sb.status_seen[STATUS_BAD_POS]);
      $display("not found %0d, search hits %0d, list filled %0d times, emptied %0d times",
               sb.status_seen[STATUS_NOT_FOUND], sb.search_hits, sb.times_full,
               sb.times_emptied);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("bounded_array_list_engine_unit test passed");
      end else begin
         $display("bounded_array_list_engine_unit test failed");
      end
      $finish;
   end

endmodule
